// File: design/qsm_pkg.sv
// Shared types and fixed-point constants for the quaternion scale-to-matrix pipeline.
package qsm_pkg;

    localparam int QUAT_W  = 16;              // Q2.14 quaternion component
    localparam int SCALE_W = 16;              // Q8.8 scale
    localparam int FIX_W   = 32;              // Q16.16 result and translation
    localparam int PROD_W  = 2 * QUAT_W;      // Q4.28 quaternion product
    localparam int SUM_W   = PROD_W + 1;      // Q.28 sum of two products
    localparam int MUL_W   = SCALE_W + SUM_W; // Q.36 scaled sum
    localparam int OUT_SHIFT = 19;            // factor two and Q.36 -> Q16.16
    localparam int N_ENTRY = 9;

    localparam logic signed [SUM_W-1:0] HALF_Q28 = SUM_W'(1) <<< 27;
    localparam logic signed [MUL_W-1:0] ROUND_BIAS = MUL_W'(1) <<< (OUT_SHIFT - 1);
    localparam logic signed [MUL_W-1:0] SAT_MAX = (MUL_W'(1) <<< (FIX_W - 1)) - MUL_W'(1);
    localparam logic signed [MUL_W-1:0] SAT_MIN = -(MUL_W'(1) <<< (FIX_W - 1));

    typedef struct packed {
        logic signed [QUAT_W-1:0]  rot_x;
        logic signed [QUAT_W-1:0]  rot_y;
        logic signed [QUAT_W-1:0]  rot_z;
        logic signed [QUAT_W-1:0]  rot_w;
        logic signed [SCALE_W-1:0] scale_x;
        logic signed [SCALE_W-1:0] scale_y;
        logic signed [SCALE_W-1:0] scale_z;
        logic signed [FIX_W-1:0]   shift_x;
        logic signed [FIX_W-1:0]   shift_y;
        logic signed [FIX_W-1:0]   shift_z;
    } t_request;

    typedef struct packed {
        logic signed [FIX_W-1:0] axis_x_0;
        logic signed [FIX_W-1:0] axis_x_1;
        logic signed [FIX_W-1:0] axis_x_2;
        logic signed [FIX_W-1:0] axis_y_0;
        logic signed [FIX_W-1:0] axis_y_1;
        logic signed [FIX_W-1:0] axis_y_2;
        logic signed [FIX_W-1:0] axis_z_0;
        logic signed [FIX_W-1:0] axis_z_1;
        logic signed [FIX_W-1:0] axis_z_2;
        logic signed [FIX_W-1:0] move_x;
        logic signed [FIX_W-1:0] move_y;
        logic signed [FIX_W-1:0] move_z;
    } t_result;

    // Stage boundary between the quaternion front end and the scaling back end.
    typedef struct packed {
        logic                              vld;
        logic [N_ENTRY-1:0][SUM_W-1:0]     sum;
        logic signed [SCALE_W-1:0]         scale_x;
        logic signed [SCALE_W-1:0]         scale_y;
        logic signed [SCALE_W-1:0]         scale_z;
        logic signed [FIX_W-1:0]           shift_x;
        logic signed [FIX_W-1:0]           shift_y;
        logic signed [FIX_W-1:0]           shift_z;
    } t_sum_stage;

endpackage

// File: design/qsm_quat.sv
// Quaternion front end: product stage and sum stage.
module qsm_quat (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  qsm_pkg::t_request    i_request,
    output qsm_pkg::t_sum_stage  o_stage
);

    logic                                 r_vld;
    logic signed [qsm_pkg::PROD_W-1:0]    r_xx, r_xy, r_xz, r_xw;
    logic signed [qsm_pkg::PROD_W-1:0]    r_yy, r_yz, r_yw, r_zz, r_zw;
    qsm_pkg::t_request                    r_req;
    qsm_pkg::t_sum_stage                  r_stage;
    qsm_pkg::t_sum_stage                  n_stage;

    // Stage 1: nine quaternion products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_xx  <= i_request.rot_x * i_request.rot_x;
        r_xy  <= i_request.rot_x * i_request.rot_y;
        r_xz  <= i_request.rot_x * i_request.rot_z;
        r_xw  <= i_request.rot_x * i_request.rot_w;
        r_yy  <= i_request.rot_y * i_request.rot_y;
        r_yz  <= i_request.rot_y * i_request.rot_z;
        r_yw  <= i_request.rot_y * i_request.rot_w;
        r_zz  <= i_request.rot_z * i_request.rot_z;
        r_zw  <= i_request.rot_z * i_request.rot_w;
        r_req <= i_request;
    end

    // Stage 2: sums of products in Q.28
    always_comb begin
        logic signed [qsm_pkg::SUM_W-1:0] xx, xy, xz, xw, yy, yz, yw, zz, zw;
        xx = qsm_pkg::SUM_W'(r_xx);
        xy = qsm_pkg::SUM_W'(r_xy);
        xz = qsm_pkg::SUM_W'(r_xz);
        xw = qsm_pkg::SUM_W'(r_xw);
        yy = qsm_pkg::SUM_W'(r_yy);
        yz = qsm_pkg::SUM_W'(r_yz);
        yw = qsm_pkg::SUM_W'(r_yw);
        zz = qsm_pkg::SUM_W'(r_zz);
        zw = qsm_pkg::SUM_W'(r_zw);
        n_stage.vld    = r_vld;
        n_stage.sum[0] = qsm_pkg::HALF_Q28 - yy - zz;
        n_stage.sum[1] = xy + zw;
        n_stage.sum[2] = xz - yw;
        n_stage.sum[3] = xy - zw;
        n_stage.sum[4] = qsm_pkg::HALF_Q28 - xx - zz;
        n_stage.sum[5] = xw + yz;
        n_stage.sum[6] = xz + yw;
        n_stage.sum[7] = yz - xw;
        n_stage.sum[8] = qsm_pkg::HALF_Q28 - xx - yy;
        n_stage.scale_x = r_req.scale_x;
        n_stage.scale_y = r_req.scale_y;
        n_stage.scale_z = r_req.scale_z;
        n_stage.shift_x = r_req.shift_x;
        n_stage.shift_y = r_req.shift_y;
        n_stage.shift_z = r_req.shift_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else begin
            r_stage.vld <= n_stage.vld;
        end
        r_stage.sum     <= n_stage.sum;
        r_stage.scale_x <= n_stage.scale_x;
        r_stage.scale_y <= n_stage.scale_y;
        r_stage.scale_z <= n_stage.scale_z;
        r_stage.shift_x <= n_stage.shift_x;
        r_stage.shift_y <= n_stage.shift_y;
        r_stage.shift_z <= n_stage.shift_z;
    end

    assign o_stage = r_stage;

endmodule

// File: design/qsm_scale.sv
// Scaling back end: scale multiply stage, then round and saturate stage.
module qsm_scale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qsm_pkg::t_sum_stage  i_stage,
    output logic                 o_valid,
    output qsm_pkg::t_result     o_result
);

    logic                                              r_vld;
    logic [qsm_pkg::N_ENTRY-1:0][qsm_pkg::MUL_W-1:0]   r_prod;
    logic signed [qsm_pkg::FIX_W-1:0]                  r_shift_x, r_shift_y, r_shift_z;
    logic [qsm_pkg::N_ENTRY-1:0][qsm_pkg::FIX_W-1:0]   n_entry;
    logic                                              r_out_vld;
    qsm_pkg::t_result                                  r_result;

    // Stage 3: scale times sum; entries 0-2 use x, 3-5 y, 6-8 z
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_stage.vld;
        end
        for (int i = 0; i < qsm_pkg::N_ENTRY; i++) begin
            logic signed [qsm_pkg::SCALE_W-1:0] sc;
            sc = (i < 3) ? i_stage.scale_x : ((i < 6) ? i_stage.scale_y : i_stage.scale_z);
            r_prod[i] <= qsm_pkg::MUL_W'(sc) * qsm_pkg::MUL_W'($signed(i_stage.sum[i]));
        end
        r_shift_x <= i_stage.shift_x;
        r_shift_y <= i_stage.shift_y;
        r_shift_z <= i_stage.shift_z;
    end

    // Stage 4: round half up, drop to Q16.16, clamp
    always_comb begin
        for (int i = 0; i < qsm_pkg::N_ENTRY; i++) begin
            logic signed [qsm_pkg::MUL_W-1:0] rnd;
            rnd = ($signed(r_prod[i]) + qsm_pkg::ROUND_BIAS) >>> qsm_pkg::OUT_SHIFT;
            if (rnd > qsm_pkg::SAT_MAX) begin
                n_entry[i] = qsm_pkg::SAT_MAX[qsm_pkg::FIX_W-1:0];
            end else if (rnd < qsm_pkg::SAT_MIN) begin
                n_entry[i] = qsm_pkg::SAT_MIN[qsm_pkg::FIX_W-1:0];
            end else begin
                n_entry[i] = rnd[qsm_pkg::FIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld;
        end
        r_result.axis_x_0 <= n_entry[0];
        r_result.axis_x_1 <= n_entry[1];
        r_result.axis_x_2 <= n_entry[2];
        r_result.axis_y_0 <= n_entry[3];
        r_result.axis_y_1 <= n_entry[4];
        r_result.axis_y_2 <= n_entry[5];
        r_result.axis_z_0 <= n_entry[6];
        r_result.axis_z_1 <= n_entry[7];
        r_result.axis_z_2 <= n_entry[8];
        r_result.move_x   <= r_shift_x;
        r_result.move_y   <= r_shift_y;
        r_result.move_z   <= r_shift_z;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_result;

endmodule

// File: design/quaternion_scale_to_matrix.sv
// Top level of the quaternion scale-to-matrix pipeline.
// Usage:
//   Drive a transform on i_request and pulse start for one cycle per request.
//   busy is always low, so a request is taken at every edge where start is
//   high: one transform per cycle, back to back, with no gaps required.
//   Four register stages: quaternion products, sums of products, scale
//   multiply, round and saturate. The result for each request passes through
//   these stages in that order and appears on o_result with o_valid high
//   once the round and saturate register is loaded; results leave in request order.
//   Each result is held for exactly one cycle and the receiver must take it;
//   there is no backpressure. Throughput is set by the nine 16x16 product
//   multipliers and nine 16x33 scale multipliers, each used once per request.
//   Synchronous reset (i_rst_n low) clears all stage valid bits, so no stale
//   result is issued after reset; data registers keep whatever they held.
module quaternion_scale_to_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  qsm_pkg::t_request  i_request,
    output logic               o_valid,
    output qsm_pkg::t_result   o_result
);

    qsm_pkg::t_sum_stage w_stage;

    assign busy = 1'b0;

    qsm_quat u_quat (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (start & ~busy),
        .i_request (i_request),
        .o_stage   (w_stage)
    );

    qsm_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (w_stage),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
